// ===== src/fpfa_pkg.sv =====
// fpfa_pkg: shared widths, codes and types of the fixed partition fit allocator
// no dependencies; compiled first

package fpfa_pkg;

   localparam int DEFAULT_SLOTS = 16;

   // payload field widths
   localparam int ACT_W      = 2;
   localparam int SLOT_W     = 4;
   localparam int BYTES_W    = 16;
   localparam int ID_W       = 8;
   localparam int STAT_W     = 3;
   localparam int GID_W      = 5;
   localparam int POL_W      = 2;
   localparam int ACNT_W     = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   // action codes of an input beat
   localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd1;
   localparam logic [ACT_W-1:0] ACT_FREE  = 2'd2;

   // result status codes
   localparam logic [STAT_W-1:0] STAT_ALLOCATED = 3'd0;
   localparam logic [STAT_W-1:0] STAT_NO_FIT    = 3'd1;
   localparam logic [STAT_W-1:0] STAT_FREED     = 3'd2;
   localparam logic [STAT_W-1:0] STAT_NOT_ALLOC = 3'd3;
   localparam logic [STAT_W-1:0] STAT_INVALID   = 3'd4;
   localparam logic [STAT_W-1:0] STAT_LOADED    = 3'd5;

   // fit policies
   localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
   localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
   localparam logic [POL_W-1:0] POL_WORST = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIT_POLICY   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_COUNT = 2'd1;

   // operation carried by the scan token
   typedef enum logic [1:0] {
      OP_NONE,
      OP_LOAD,
      OP_ALLOC,
      OP_FREE
   } op_type;

   // scan token handed from cell to cell
   typedef struct packed {
      logic               valid;
      op_type             op;
      logic [BYTES_W-1:0] arg;        // request size or load size
      logic               found;
      logic [BYTES_W-1:0] best_size;
      logic               freed;
      logic [1:0]         free_cnt;   // saturates at two
   } tok_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [GID_W-1:0]  granted_id;
      logic              all_full;
   } res_type;

endpackage

// ===== src/fpfa_req_if.sv =====
// fpfa_req_if: input channel, valid/ready plus request payload
// depends on fpfa_pkg

interface fpfa_req_if;
   logic                          valid;
   logic                          ready;
   logic [fpfa_pkg::ACT_W-1:0]    action;
   logic [fpfa_pkg::SLOT_W-1:0]   slot_index;
   logic [fpfa_pkg::BYTES_W-1:0]  partition_bytes;
   logic [fpfa_pkg::BYTES_W-1:0]  request_size;
   logic [fpfa_pkg::ID_W-1:0]     block_id;

   modport source (
      output valid, action, slot_index, partition_bytes, request_size, block_id,
      input  ready
   );
   modport sink (
      input  valid, action, slot_index, partition_bytes, request_size, block_id,
      output ready
   );
endinterface

// ===== src/fpfa_rsp_if.sv =====
// fpfa_rsp_if: result channel, valid/ready plus result payload
// depends on fpfa_pkg

interface fpfa_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [fpfa_pkg::STAT_W-1:0]  status;
   logic [fpfa_pkg::GID_W-1:0]   granted_id;
   logic                         all_full;

   modport source (
      output valid, status, granted_id, all_full,
      input  ready
   );
   modport sink (
      input  valid, status, granted_id, all_full,
      output ready
   );
endinterface

// ===== src/fpfa_csr_if.sv =====
// fpfa_csr_if: register write channel, valid/ready plus index and data
// depends on fpfa_pkg

interface fpfa_csr_if;
   logic                             valid;
   logic                             ready;
   logic [fpfa_pkg::CSR_IDX_W-1:0]   index;
   logic [fpfa_pkg::CSR_DATA_W-1:0]  data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

// ===== src/fixed_partition_fit_allocator.sv =====
// Fixed partition allocator with first, best and worst fit. Each input beat
// (load, allocate or free) sends one token down a chain of SLOTS cells, one
// cell per cycle, and yields exactly one result beat. The input is open only
// while the block is idle. The accept edge loads the token into the head
// register, each cell registers it in turn and the result is registered as
// it leaves the last cell, after which the input reopens once the output can
// take the result. The next beat is accepted even while the previous result
// still waits on the output; a second finished result then waits in a hold
// register and the input stays closed until the output frees. Partition
// sizes read as undefined until a load writes them; in-use marks and the
// two registers clear on reset. The user must write registers through the
// csr channel only while the block is idle; the block itself does not
// enforce it. Registers: index 0 fit policy, index 1 active count.
// depends on fpfa_pkg, the channel interfaces, fpfa_cell and fpfa_ctrl

module fixed_partition_fit_allocator #(
   parameter int   SLOTS = fpfa_pkg::DEFAULT_SLOTS,
   localparam int  IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
   localparam int  CNT_W = $clog2(SLOTS + 1)
) (
   input  logic        clock,
   input  logic        reset,
   fpfa_req_if.sink    req_chan,
   fpfa_rsp_if.source  rsp_chan,
   fpfa_csr_if.sink    csr_chan
);
   import fpfa_pkg::*;

   // token path: entry k feeds cell k, entry SLOTS is the chain output
   tok_type            tok_chain  [0:SLOTS];
   logic [IDX_W-1:0]   tgt_chain  [0:SLOTS];
   logic [IDX_W-1:0]   best_chain [0:SLOTS];

   // broadcast from the controller to every cell
   logic [POL_W-1:0]   policy;
   logic [CNT_W-1:0]   live;
   logic               set_en;
   logic [IDX_W-1:0]   set_idx;

   // decode, registers and output stage
   fpfa_ctrl #(
      .SLOTS (SLOTS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_chan  (csr_chan),
      .policy    (policy),
      .live      (live),
      .tok_head  (tok_chain[0]),
      .tgt_head  (tgt_chain[0]),
      .tok_tail  (tok_chain[SLOTS]),
      .tgt_tail  (tgt_chain[SLOTS]),
      .best_tail (best_chain[SLOTS]),
      .set_en    (set_en),
      .set_idx   (set_idx)
   );

   // no candidate enters the chain; a cell fills it when it takes the token
   assign best_chain[0] = '0;

   // row of slot cells, lowest id first so ties go to the lower id
   for (genvar k = 0; k < SLOTS; k++) begin : g_cell
      fpfa_cell #(
         .SLOTS   (SLOTS),
         .CELL_ID (k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .policy   (policy),
         .live     (live),
         .tok_in   (tok_chain[k]),
         .tgt_in   (tgt_chain[k]),
         .best_in  (best_chain[k]),
         .set_en   (set_en),
         .set_idx  (set_idx),
         .tok_out  (tok_chain[k+1]),
         .tgt_out  (tgt_chain[k+1]),
         .best_out (best_chain[k+1])
      );
   end

endmodule

// ===== src/fpfa_cell.sv =====
// fpfa_cell: one partition slot of the chain, holds size and in-use mark
// depends on fpfa_pkg; one scan token passes through per cycle

module fpfa_cell #(
   parameter int   SLOTS   = fpfa_pkg::DEFAULT_SLOTS,
   parameter int   CELL_ID = 0,
   localparam int  IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1,
   localparam int  CNT_W   = $clog2(SLOTS + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [fpfa_pkg::POL_W-1:0] policy,
   input  logic [CNT_W-1:0]           live,
   input  fpfa_pkg::tok_type          tok_in,
   input  logic [IDX_W-1:0]           tgt_in,
   input  logic [IDX_W-1:0]           best_in,
   input  logic                       set_en,
   input  logic [IDX_W-1:0]           set_idx,
   output fpfa_pkg::tok_type          tok_out,
   output logic [IDX_W-1:0]           tgt_out,
   output logic [IDX_W-1:0]           best_out
);
   import fpfa_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_ID);

   logic [BYTES_W-1:0] size_ff, size_in;
   logic               use_ff, use_in;
   tok_type            tok_ff, tok_in_next;
   logic [IDX_W-1:0]   tgt_ff, best_ff, best_in_next;
   logic               active, hit, free_now, fits, take;

   assign active   = live > CNT_W'(CELL_ID);
   assign hit      = tok_in.valid && (tgt_in == MY_IDX);
   assign free_now = active && !use_ff;
   assign fits     = size_ff >= tok_in.arg;

   // allocate candidate selection; ties keep the lower id already held
   always_comb begin
      case (policy)
         POL_WORST: take = free_now && (!tok_in.found || size_ff > tok_in.best_size);
         POL_BEST:  take = free_now && fits && (!tok_in.found || size_ff < tok_in.best_size);
         default:   take = free_now && fits && !tok_in.found;
      endcase
   end

   always_comb begin
      size_in      = size_ff;
      use_in       = use_ff;
      tok_in_next  = tok_in;
      best_in_next = best_in;
      if (set_en && set_idx == MY_IDX) begin
         use_in = 1'b1;
      end
      if (tok_in.valid) begin
         case (tok_in.op)
            OP_LOAD: begin
               if (hit) begin
                  size_in = tok_in.arg;
                  use_in  = 1'b0;
               end
            end
            OP_FREE: begin
               if (hit && use_ff) begin
                  use_in            = 1'b0;
                  tok_in_next.freed = 1'b1;
               end
            end
            OP_ALLOC: begin
               if (take) begin
                  tok_in_next.found     = 1'b1;
                  tok_in_next.best_size = size_ff;
                  best_in_next          = MY_IDX;
               end
            end
            default: begin
            end
         endcase
         // count free active slots as they stand after this beat's update
         if (active && !use_in && tok_in.free_cnt != 2'd2) begin
            tok_in_next.free_cnt = tok_in.free_cnt + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         use_ff <= 1'b0;
         tok_ff <= '0;
      end else begin
         use_ff <= use_in;
         tok_ff <= tok_in_next;
      end
   end

   always_ff @(posedge clock) begin
      size_ff <= size_in;
      tgt_ff  <= tgt_in;
      best_ff <= best_in_next;
   end

   assign tok_out  = tok_ff;
   assign tgt_out  = tgt_ff;
   assign best_out = best_ff;

endmodule

// ===== src/fpfa_ctrl.sv =====
// fpfa_ctrl: registers, beat decode, token launch and result delivery
// depends on fpfa_pkg and the channel interfaces

module fpfa_ctrl #(
   parameter int   SLOTS = fpfa_pkg::DEFAULT_SLOTS,
   localparam int  IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
   localparam int  CNT_W = $clog2(SLOTS + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   fpfa_req_if.sink                   req_chan,
   fpfa_rsp_if.source                 rsp_chan,
   fpfa_csr_if.sink                   csr_chan,
   output logic [fpfa_pkg::POL_W-1:0] policy,
   output logic [CNT_W-1:0]           live,
   output fpfa_pkg::tok_type          tok_head,
   output logic [IDX_W-1:0]           tgt_head,
   input  fpfa_pkg::tok_type          tok_tail,
   input  logic [IDX_W-1:0]           tgt_tail,
   input  logic [IDX_W-1:0]           best_tail,
   output logic                       set_en,
   output logic [IDX_W-1:0]           set_idx
);
   import fpfa_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_HOLD
   } state_type;

   state_type          state_ff, state_in;
   tok_type            head_ff, head_in;
   logic [IDX_W-1:0]   tgt_ff, tgt_in;
   res_type            rsp_ff, rsp_in, hold_ff, hold_in, done_res;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [POL_W-1:0]   policy_ff, policy_in;
   logic [ACNT_W-1:0]  active_ff, active_in;
   logic               req_fire, csr_fire, out_free, slot_ok, id_ok, alloc_ok;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign csr_fire = csr_chan.valid && csr_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign live    = (32'(active_ff) > SLOTS) ? CNT_W'(SLOTS) : CNT_W'(active_ff);
   assign slot_ok = 32'(req_chan.slot_index) < SLOTS;
   assign id_ok   = (req_chan.block_id != '0) && (32'(req_chan.block_id) <= 32'(live));

   // worst fit carries the largest free slot even when it is too small
   assign alloc_ok = tok_tail.found && (tok_tail.best_size >= tok_tail.arg);

   // result of the token leaving the last cell
   always_comb begin
      done_res.granted_id = '0;
      case (tok_tail.op)
         OP_LOAD: done_res.status = STAT_LOADED;
         OP_ALLOC: begin
            if (alloc_ok) begin
               done_res.status     = STAT_ALLOCATED;
               done_res.granted_id = GID_W'(32'(best_tail) + 1);
            end else begin
               done_res.status = STAT_NO_FIT;
            end
         end
         OP_FREE: begin
            if (tok_tail.freed) begin
               done_res.status     = STAT_FREED;
               done_res.granted_id = GID_W'(32'(tgt_tail) + 1);
            end else begin
               done_res.status = STAT_NOT_ALLOC;
            end
         end
         default: done_res.status = STAT_INVALID;
      endcase
      done_res.all_full = (tok_tail.free_cnt == 2'd0) ||
                          (tok_tail.op == OP_ALLOC && alloc_ok &&
                           tok_tail.free_cnt == 2'd1);
   end

   assign set_en  = tok_tail.valid && tok_tail.op == OP_ALLOC && alloc_ok;
   assign set_idx = best_tail;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      head_in.valid = 1'b0;
      tgt_in       = tgt_ff;
      rsp_in       = rsp_ff;
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      policy_in    = policy_ff;
      active_in    = active_ff;

      if (csr_fire) begin
         case (csr_chan.index)
            CSR_FIT_POLICY:   policy_in = csr_chan.data[POL_W-1:0];
            CSR_ACTIVE_COUNT: active_in = csr_chan.data[ACNT_W-1:0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               head_in.valid     = 1'b1;
               head_in.found     = 1'b0;
               head_in.best_size = '0;
               head_in.freed     = 1'b0;
               head_in.free_cnt  = 2'd0;
               head_in.arg       = (req_chan.action == ACT_ALLOC) ?
                                   req_chan.request_size : req_chan.partition_bytes;
               if (req_chan.action == ACT_LOAD) begin
                  tgt_in = IDX_W'(req_chan.slot_index);
               end else begin
                  tgt_in = IDX_W'(req_chan.block_id - 8'd1);
               end
               case (req_chan.action)
                  ACT_LOAD:  head_in.op = slot_ok ? OP_LOAD : OP_NONE;
                  ACT_ALLOC: head_in.op = OP_ALLOC;
                  ACT_FREE:  head_in.op = id_ok ? OP_FREE : OP_NONE;
                  default:   head_in.op = OP_NONE;
               endcase
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (tok_tail.valid) begin
               if (out_free) begin
                  rsp_in       = done_res;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  hold_in  = done_res;
                  state_in = S_HOLD;
               end
            end
         end
         S_HOLD: begin
            if (out_free) begin
               rsp_in       = hold_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         policy_ff    <= POL_FIRST;
         active_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
         policy_ff    <= policy_in;
         active_ff    <= active_in;
      end
      tgt_ff  <= tgt_in;
      rsp_ff  <= rsp_in;
      hold_ff <= hold_in;
   end

   assign req_chan.ready      = state_ff == S_IDLE;
   assign csr_chan.ready      = 1'b1;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_ff.status;
   assign rsp_chan.granted_id = rsp_ff.granted_id;
   assign rsp_chan.all_full   = rsp_ff.all_full;
   assign policy              = policy_ff;
   assign tok_head            = head_ff;
   assign tgt_head            = tgt_ff;

`ifndef SYNTHESIS
   // a token reaches the end of the chain only while a scan is open
   a_tail_in_scan: assert property (@(posedge clock) disable iff (reset)
      tok_tail.valid |-> state_ff == S_SCAN)
      else $error("token left the chain outside a scan");

   // an accepted beat closes the input until its result is out
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_chan.ready)
      else $error("input reopened right after accept");

   // a result waits in the hold register only behind a pending output beat
   a_hold_needs_busy_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_HOLD |-> rsp_valid_ff)
      else $error("result held while output was free");

   // only allocated and freed results carry an id
   a_id_only_when_granted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != STAT_ALLOCATED && rsp_ff.status != STAT_FREED)
      |-> rsp_ff.granted_id == '0)
      else $error("id reported with a status that grants none");
`endif

endmodule

// ===== bench/tb.sv =====
// tb: self-checking bench for fixed_partition_fit_allocator
// drives load, allocate and free beats and checks each result against a predictor
// depends on fpfa_pkg, fpfa_req_if, fpfa_rsp_if, fpfa_csr_if and the allocator rtl
`timescale 1ns / 100ps

module tb;
   import fpfa_pkg::*;

   localparam int SLOTS          = DEFAULT_SLOTS;
   localparam int CLK_HALF       = 5;
   localparam int RESET_CYCLES   = 7;
   localparam int SETTLE_CYCLES  = SLOTS + 6;
   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS    = 10;
   localparam int PHASE_ITEMS    = 90;
   localparam int NUM_PHASES     = 11;
   localparam int HOLD_PHASE     = 3;

   // codes the package leaves unnamed
   localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
   localparam logic [POL_W-1:0] POL_ALIAS  = 2'd3;   // decodes as first fit

   // register settings of the random phases, extremes included
   localparam logic [POL_W-1:0] PHASE_POLICY [NUM_PHASES] = '{
      POL_WORST, POL_FIRST, POL_BEST, POL_ALIAS, POL_WORST, POL_FIRST,
      POL_BEST, POL_WORST, POL_FIRST, POL_BEST, POL_WORST
   };
   localparam logic [ACNT_W-1:0] PHASE_COUNT [NUM_PHASES] = '{
      5'd16, 5'd31, 5'd5, 5'd16, 5'd1, 5'd0, 5'd16, 5'd9, 5'd16, 5'd31, 5'd3
   };

   // a few sizes shared by loads and requests so that ties and exact fits happen
   localparam logic [BYTES_W-1:0] SIZE_POOL [6] = '{
      16'd0, 16'd64, 16'd500, 16'd2048, 16'd40000, 16'hFFFF
   };

   // partition sizes written before any slot is active, so no unwritten slot is ever read
   localparam logic [BYTES_W-1:0] BOOT_SIZES [SLOTS] = '{
      16'd0, 16'd300, 16'd700, 16'd500, 16'd900, 16'd500, 16'd1200, 16'd64,
      16'd2048, 16'd4096, 16'd500, 16'd8191, 16'd16384, 16'd32768, 16'd40000, 16'hFFFF
   };

   typedef struct packed {
      logic [ACT_W-1:0]   action;
      logic [SLOT_W-1:0]  slot_index;
      logic [BYTES_W-1:0] partition_bytes;
      logic [BYTES_W-1:0] request_size;
      logic [ID_W-1:0]    block_id;
   } alloc_req_type;

   logic clock;
   logic reset;

   fpfa_req_if req_bus ();
   fpfa_rsp_if rsp_bus ();
   fpfa_csr_if csr_bus ();

   fixed_partition_fit_allocator #(.SLOTS(SLOTS)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // predictor state: its own copy of the slot table and both registers
   logic [BYTES_W-1:0] part_size [SLOTS];
   logic               slot_used [SLOTS];
   logic [POL_W-1:0]   cfg_policy;
   logic [ACNT_W-1:0]  cfg_count;

   alloc_req_type  backlog [$];          // beats waiting for the driver
   res_type        awaited_outcomes [$]; // predicted results, oldest first
   alloc_req_type  in_flight;

   int unsigned gap_left;
   int unsigned gap_ceiling;
   int unsigned stall_left;
   int unsigned stall_ceiling;
   logic        rsp_hold  = 1'b0;
   logic        hold_armed = 1'b0;

   int unsigned error_count;
   int unsigned items_sent;
   int unsigned results_seen;
   int unsigned grants_seen;
   int unsigned misses_seen;
   int unsigned full_seen;
   int unsigned quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // one step of the allocator: updates the predictor state, returns the result beat
   function automatic res_type allocator_step(input alloc_req_type rq);
      res_type     r;
      int unsigned live;
      int          pick;
      logic        all_used;
      live         = (cfg_count > SLOTS) ? SLOTS : cfg_count;
      r.status     = STAT_INVALID;
      r.granted_id = '0;
      pick         = -1;
      case (rq.action)
         ACT_LOAD: begin
            // any slot below SLOTS may be loaded, also past the active count
            part_size[rq.slot_index] = rq.partition_bytes;
            slot_used[rq.slot_index] = 1'b0;
            r.status = STAT_LOADED;
         end
         ACT_ALLOC: begin
            for (int s = 0; s < live; s++) begin
               if (!slot_used[s]) begin
                  if (cfg_policy == POL_WORST) begin
                     // strict compare keeps the lowest id on ties
                     if (pick < 0 || part_size[s] > part_size[pick]) pick = s;
                  end else if (part_size[s] >= rq.request_size) begin
                     if (cfg_policy == POL_BEST) begin
                        if (pick < 0 || part_size[s] < part_size[pick]) pick = s;
                     end else if (pick < 0) begin
                        pick = s;
                     end
                  end
               end
            end
            // worst fit takes the largest free slot only if it is big enough
            if (cfg_policy == POL_WORST && pick >= 0 && part_size[pick] < rq.request_size)
               pick = -1;
            if (pick >= 0) begin
               slot_used[pick] = 1'b1;
               r.status     = STAT_ALLOCATED;
               r.granted_id = GID_W'(pick + 1);
            end else begin
               r.status = STAT_NO_FIT;
            end
         end
         ACT_FREE: begin
            if (rq.block_id >= 1 && rq.block_id <= live) begin
               if (slot_used[rq.block_id - 1]) begin
                  slot_used[rq.block_id - 1] = 1'b0;
                  r.status     = STAT_FREED;
                  r.granted_id = GID_W'(rq.block_id);
               end else begin
                  r.status = STAT_NOT_ALLOC;
               end
            end
         end
         default: begin
            // unused action code changes nothing
         end
      endcase
      all_used = 1'b1;
      for (int s = 0; s < live; s++)
         if (!slot_used[s]) all_used = 1'b0;
      r.all_full = all_used;
      return r;
   endfunction

   function automatic alloc_req_type make_req(input logic [ACT_W-1:0] act,
                                              input logic [SLOT_W-1:0] slot,
                                              input logic [BYTES_W-1:0] bytes,
                                              input logic [BYTES_W-1:0] want,
                                              input logic [ID_W-1:0] id);
      alloc_req_type rq;
      rq.action          = act;
      rq.slot_index      = slot;
      rq.partition_bytes = bytes;
      rq.request_size    = want;
      rq.block_id        = id;
      return rq;
   endfunction

   // appends a beat to the driver's backlog
   function automatic void add_beat(input alloc_req_type rq);
      backlog.insert(backlog.size(), rq);
   endfunction

   function automatic logic [BYTES_W-1:0] pool_size();
      if ($urandom_range(0, 2) == 0) return BYTES_W'($urandom_range(0, 5000));
      return SIZE_POOL[$urandom_range(0, 5)];
   endfunction

   // mostly allocate and free traffic so that slots fill up and drain again;
   // fields the action ignores carry random bits
   function automatic alloc_req_type random_request(input int unsigned live);
      alloc_req_type rq;
      int unsigned   mix;
      rq  = make_req(ACT_UNUSED, SLOT_W'($urandom), BYTES_W'($urandom),
                     BYTES_W'($urandom), ID_W'($urandom));
      mix = $urandom_range(0, 99);
      if (mix < 8) begin
         rq.action = ACT_LOAD;
         if ($urandom_range(0, 3) != 0) rq.partition_bytes = pool_size();
      end else if (mix < 52) begin
         rq.action = ACT_ALLOC;
         case ($urandom_range(0, 9))
            0: rq.request_size = '0;
            1: rq.request_size = '1;
            2, 3: begin
               // keep the fully random request
            end
            default: rq.request_size = BYTES_W'($urandom_range(0, pool_size()));
         endcase
      end else if (mix < 95) begin
         rq.action = ACT_FREE;
         if ($urandom_range(0, 9) != 0 && live != 0)
            rq.block_id = ID_W'($urandom_range(1, live));
      end
      return rq;
   endfunction

   task automatic note_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   // register write; only called while nothing is in flight
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      if (idx == CSR_FIT_POLICY) cfg_policy = val[POL_W-1:0];
      else cfg_count = val[ACNT_W-1:0];
      csr_bus.valid <= 1'b0;
   endtask

   // wait until every beat is sent and answered, then let the chain empty out;
   // sampled mid-cycle so the driver's updates of this edge are already visible
   task automatic settle();
      @(negedge clock);
      while (backlog.size() != 0 || req_bus.valid || awaited_outcomes.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [POL_W-1:0] pol, input logic [ACNT_W-1:0] cnt);
      settle();
      write_csr(CSR_FIT_POLICY, CSR_DATA_W'(pol));
      write_csr(CSR_ACTIVE_COUNT, CSR_DATA_W'(cnt));
   endtask

   // driver: one beat at a time from the backlog, random gap after each accept
   always @(posedge clock) begin : req_driver
      logic offer;
      if (reset) begin
         req_bus.valid <= 1'b0;
         gap_left = 0;
      end else begin
         offer = req_bus.valid;
         if (req_bus.valid && req_bus.ready) begin
            // beat taken: predict its result now, in accept order
            awaited_outcomes.insert(awaited_outcomes.size(), allocator_step(in_flight));
            items_sent++;
            gap_left = $urandom_range(0, gap_ceiling);
            offer    = 1'b0;
         end
         if (!offer) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (backlog.size() != 0) begin
               in_flight = backlog.pop_front();
               req_bus.action          <= in_flight.action;
               req_bus.slot_index      <= in_flight.slot_index;
               req_bus.partition_bytes <= in_flight.partition_bytes;
               req_bus.request_size    <= in_flight.request_size;
               req_bus.block_id        <= in_flight.block_id;
               offer = 1'b1;
            end
         end
         // single write of valid per edge so back-to-back beats keep it high
         req_bus.valid <= offer;
      end
   end

   // monitor: checks each result beat against the oldest prediction
   always @(posedge clock) begin : rsp_monitor
      res_type want;
      res_type got;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.status     = rsp_bus.status;
            got.granted_id = rsp_bus.granted_id;
            got.all_full   = rsp_bus.all_full;
            results_seen++;
            if (got.status == STAT_ALLOCATED) grants_seen++;
            if (got.status == STAT_NO_FIT) misses_seen++;
            if (got.all_full) full_seen++;
            if (awaited_outcomes.size() == 0) begin
               note_error($sformatf("result beat with none pending: status %0d id %0d full %0b",
                                    got.status, got.granted_id, got.all_full));
            end else begin
               want = awaited_outcomes.pop_front();
               if (got.status !== want.status || got.granted_id !== want.granted_id ||
                   got.all_full !== want.all_full)
                  note_error($sformatf(
                     "result %0d: expected status %0d id %0d full %0b, got %0d %0d %0b",
                     results_seen, want.status, want.granted_id, want.all_full,
                     got.status, got.granted_id, got.all_full));
            end
            stall_left = $urandom_range(0, stall_ceiling);
         end else if (stall_left != 0) begin
            stall_left--;
         end
         rsp_bus.ready <= (stall_left == 0) && !rsp_hold;
      end
   end

   // long receiver hold-off: the hold register fills and the input must back up
   initial begin : long_hold
      wait (hold_armed);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // watchdog: counts cycles in which no channel moves a beat
   always @(posedge clock) begin : watchdog
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      // every input known from time zero
      req_bus.valid           = 1'b0;
      req_bus.action          = ACT_LOAD;
      req_bus.slot_index      = '0;
      req_bus.partition_bytes = '0;
      req_bus.request_size    = '0;
      req_bus.block_id        = '0;
      csr_bus.valid           = 1'b0;
      csr_bus.index           = CSR_FIT_POLICY;
      csr_bus.data            = '0;
      rsp_bus.ready           = 1'b0;
      cfg_policy              = POL_FIRST;
      cfg_count               = '0;
      for (int s = 0; s < SLOTS; s++) begin
         part_size[s] = '0;
         slot_used[s] = 1'b0;
      end
      gap_ceiling   = 16;
      stall_ceiling = 16;
      reset = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // no active slots: allocate misses and all_full reads one
      configure(POL_FIRST, 5'd0);
      add_beat(make_req(ACT_ALLOC, '0, '0, '0, '0));
      add_beat(make_req(ACT_FREE, '0, '0, '0, 8'd1));
      add_beat(make_req(ACT_UNUSED, '1, '1, '1, '1));
      // load every slot before anything can be allocated
      for (int s = 0; s < SLOTS; s++)
         add_beat(make_req(ACT_LOAD, SLOT_W'(s), BOOT_SIZES[s], '0, '0));

      // best fit over all slots: tie on 500 goes to the lowest id, largest
      // request, zero request, bad ids and a double free
      configure(POL_BEST, 5'd16);
      add_beat(make_req(ACT_ALLOC, '0, '0, 16'd500, '0));
      add_beat(make_req(ACT_ALLOC, '0, '0, 16'hFFFF, '0));
      add_beat(make_req(ACT_ALLOC, '0, '0, 16'd0, '0));
      add_beat(make_req(ACT_FREE, '0, '0, '0, 8'd0));
      add_beat(make_req(ACT_FREE, '0, '0, '0, 8'hFF));
      add_beat(make_req(ACT_FREE, '0, '0, '0, 8'd4));
      add_beat(make_req(ACT_FREE, '0, '0, '0, 8'd4));

      // random phases; idling styles rotate so some phases run back to back
      for (int p = 0; p < NUM_PHASES; p++) begin
         configure(PHASE_POLICY[p], PHASE_COUNT[p]);
         gap_ceiling   = (p % 4 == 1 || p % 4 == 2) ? 0 : 16;
         stall_ceiling = (p % 4 == 1 || p % 4 == 3) ? 0 : 16;
         for (int i = 0; i < PHASE_ITEMS; i++)
            add_beat(random_request((PHASE_COUNT[p] > SLOTS) ? SLOTS : PHASE_COUNT[p]));
         if (p == HOLD_PHASE) hold_armed = 1'b1;
      end

      settle();
      $display("covered %0d request beats and %0d result beats over %0d register settings",
               items_sent, results_seen, NUM_PHASES + 2);
      $display("grants %0d, no-fit %0d, results with every active slot taken %0d, errors %0d",
               grants_seen, misses_seen, full_seen, error_count);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
